@@ sv/iirbq_pkg.sv @@
// shared constants and types for the biquad sample filter
`default_nettype none

package iirbq_pkg;

  // coefficient registers are signed q2.14 by default
  localparam int COEF_W = 16;
  // stored feedback value width (two's complement, wraps)
  localparam int Y_W = 32;

  localparam int DEF_SAMPLE_BITS = 12;
  localparam int DEF_COEF_FRAC_BITS = 14;

  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_B0 = 3'd0,
    REG_COEF_B1 = 3'd1,
    REG_COEF_B2 = 3'd2,
    REG_COEF_A1 = 3'd3,
    REG_COEF_A2 = 3'd4
  } reg_idx_e;

  localparam logic signed [COEF_W-1:0] RST_COEF_B0 = 16'sd544;
  localparam logic signed [COEF_W-1:0] RST_COEF_B1 = -16'sd846;
  localparam logic signed [COEF_W-1:0] RST_COEF_B2 = 16'sd544;
  localparam logic signed [COEF_W-1:0] RST_COEF_A1 = 16'sd30425;
  localparam logic signed [COEF_W-1:0] RST_COEF_A2 = -16'sd14312;

endpackage

`default_nettype wire

@@ sv/iirbq_tap_cell.sv @@
// one tap of the delay line: holds a word, weights it and adds to the passing sum
`default_nettype none

module iirbq_tap_cell #(
  parameter int DATA_W = 13,
  parameter int ACC_W  = 31
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      en_i,
  input  wire logic signed [DATA_W-1:0]            data_i,
  input  wire logic signed [iirbq_pkg::COEF_W-1:0] coef_i,
  input  wire logic signed [ACC_W-1:0]             acc_i,
  output logic signed [DATA_W-1:0]                 data_o,
  output logic signed [ACC_W-1:0]                  acc_o
);

  localparam int PROD_W = iirbq_pkg::COEF_W + DATA_W;

  logic signed [DATA_W-1:0] data_q;
  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (en_i) begin
      data_q <= data_i;
    end
  end

  assign prod   = coef_i * data_q;
  assign acc_o  = acc_i + ACC_W'(prod);
  assign data_o = data_q;

endmodule

`default_nettype wire

@@ sv/iirbq_out_skid.sv @@
// two-entry output register with skid slot
`default_nettype none

module iirbq_out_skid #(
  parameter int W = 13
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          push_valid_i,
  output logic         push_stall_o,
  input  wire  [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  wire          pop_stall_i,
  output logic [W-1:0] pop_data_o
);

  logic         main_valid_q, main_valid_d;
  logic         skid_valid_q, skid_valid_d;
  logic [W-1:0] main_data_q, main_data_d;
  logic [W-1:0] skid_data_q, skid_data_d;
  logic         push, pop;

  assign push_stall_o = skid_valid_q;
  assign push = push_valid_i && !skid_valid_q;
  assign pop  = main_valid_q && !pop_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_data_d  = main_data_q;
    skid_data_d  = skid_data_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_data_d  = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        main_data_d  = push_data_i;
        main_valid_d = push;
      end
    end else if (push) begin
      if (!main_valid_q) begin
        main_data_d  = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_data_q <= main_data_d;
    skid_data_q <= skid_data_d;
  end

  assign pop_valid_o = main_valid_q;
  assign pop_data_o  = main_data_q;

  // a waiting word in the skid slot always has one ahead of it
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid slot holds a word while main register is empty");

  // a word arriving behind a stalled one must land in the skid slot
  a_push_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && main_valid_q && pop_stall_i) |=> (skid_valid_q && skid_data_q == $past(push_data_i)))
    else $error("word lost while output stalled");

  // draining the skid slot moves its word forward
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && skid_valid_q) |=> (main_valid_q && main_data_q == $past(skid_data_q)))
    else $error("skid word not moved to main register");

endmodule

`default_nettype wire

@@ sv/iir_biquad_sample_filter.sv @@
// top level of the second-order direct form i sample filter
`default_nettype none

// second-order iir filter, direct form i. each accepted word x gives one result
//   y = b0*x + b1*x1 + b2*x2 + floor((a1*y1 + a2*y2) / 2^COEF_FRAC_BITS)
// with the feedback terms added. coefficients are signed 16-bit fixed point with
// COEF_FRAC_BITS fraction bits (q2.14 by default), written through the plain
// register port (index 0..4 = b0, b1, b2, a1, a2; other indexes are ignored).
// y is kept as a 32-bit two's complement value that wraps on overflow and feeds
// back unsaturated; the output is its integer part truncated toward zero and
// clamped to 0..2^SAMPLE_BITS-1, with clipped set when the clamp was needed.
// the delay line is a row of tap cells: two holding past inputs, two holding
// past outputs, each weighting its word and adding to the sum passed along.
// throughput is one word per clock while in_stall_o is low; the critical path
// is the feedback loop through the two output-tap multipliers and the final
// add back into the first output cell. a two-entry output register lets a new
// word be taken while a finished result is still stalled; in_stall_o rises only
// once both entries are full. configuration must only change while idle.
module iir_biquad_sample_filter #(
  parameter int SAMPLE_BITS    = iirbq_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = iirbq_pkg::DEF_COEF_FRAC_BITS
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // register port
  input  wire                                 cfg_we_i,
  input  wire  [iirbq_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [iirbq_pkg::COEF_W-1:0]        cfg_wdata_i,
  // input words
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire  [SAMPLE_BITS-1:0]              sample_in_i,
  // result words
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [SAMPLE_BITS-1:0]              sample_out_o,
  output logic                                clipped_o
);

  localparam int COEF_W = iirbq_pkg::COEF_W;
  localparam int Y_W    = iirbq_pkg::Y_W;
  // input samples carried as signed with a zero sign bit
  localparam int X_W    = SAMPLE_BITS + 1;
  // feedforward sum of three products
  localparam int FF_W   = COEF_W + X_W + 2;
  // feedback sum of two products
  localparam int FB_W   = COEF_W + Y_W + 1;
  localparam int SUM_W  = (FF_W > FB_W) ? FF_W : FB_W;
  localparam logic signed [Y_W-1:0] SMAX_Y = Y_W'((1 << SAMPLE_BITS) - 1);

  // coefficient registers
  logic signed [COEF_W-1:0] coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b0_q <= iirbq_pkg::RST_COEF_B0;
      coef_b1_q <= iirbq_pkg::RST_COEF_B1;
      coef_b2_q <= iirbq_pkg::RST_COEF_B2;
      coef_a1_q <= iirbq_pkg::RST_COEF_A1;
      coef_a2_q <= iirbq_pkg::RST_COEF_A2;
    end else if (cfg_we_i) begin
      unique case (iirbq_pkg::reg_idx_e'(cfg_idx_i))
        iirbq_pkg::REG_COEF_B0: coef_b0_q <= cfg_wdata_i;
        iirbq_pkg::REG_COEF_B1: coef_b1_q <= cfg_wdata_i;
        iirbq_pkg::REG_COEF_B2: coef_b2_q <= cfg_wdata_i;
        iirbq_pkg::REG_COEF_A1: coef_a1_q <= cfg_wdata_i;
        iirbq_pkg::REG_COEF_A2: coef_a2_q <= cfg_wdata_i;
        default: ; // unused indexes ignored
      endcase
    end
  end

  // handshake: cells shift on every accepted word
  logic in_accept;
  assign in_accept = in_valid_i && !in_stall_o;

  // current input tap, start of the feedforward sum
  logic signed [X_W-1:0]          x_cur;
  logic signed [COEF_W+X_W-1:0]   prod_b0;
  logic signed [FF_W-1:0]         ff_b0, ff_b1, ff_sum;
  logic signed [X_W-1:0]          x1_data, x2_data;

  assign x_cur   = $signed({1'b0, sample_in_i});
  assign prod_b0 = coef_b0_q * x_cur;
  assign ff_b0   = FF_W'(prod_b0);

  iirbq_tap_cell #(.DATA_W(X_W), .ACC_W(FF_W)) u_cell_x1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (in_accept),
    .data_i (x_cur),
    .coef_i (coef_b1_q),
    .acc_i  (ff_b0),
    .data_o (x1_data),
    .acc_o  (ff_b1)
  );

  iirbq_tap_cell #(.DATA_W(X_W), .ACC_W(FF_W)) u_cell_x2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (in_accept),
    .data_i (x1_data),
    .coef_i (coef_b2_q),
    .acc_i  (ff_b1),
    .data_o (x2_data),
    .acc_o  (ff_sum)
  );

  // output taps: feedback sum, then one floor shift
  logic signed [Y_W-1:0]  y_new, y1_data, y2_data;
  logic signed [FB_W-1:0] fb_a1, fb_sum, fb_shr;
  logic signed [SUM_W-1:0] y_full;

  iirbq_tap_cell #(.DATA_W(Y_W), .ACC_W(FB_W)) u_cell_y1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (in_accept),
    .data_i (y_new),
    .coef_i (coef_a1_q),
    .acc_i  ('0),
    .data_o (y1_data),
    .acc_o  (fb_a1)
  );

  iirbq_tap_cell #(.DATA_W(Y_W), .ACC_W(FB_W)) u_cell_y2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (in_accept),
    .data_i (y1_data),
    .coef_i (coef_a2_q),
    .acc_i  (fb_a1),
    .data_o (y2_data),
    .acc_o  (fb_sum)
  );

  // arithmetic shift is the floor division
  assign fb_shr = fb_sum >>> COEF_FRAC_BITS;
  assign y_full = SUM_W'(ff_sum) + SUM_W'(fb_shr);
  // stored value wraps modulo 2^32
  assign y_new  = y_full[Y_W-1:0];

  // integer part, truncated toward zero, then clamped
  logic signed [Y_W-1:0]   y_shr;
  logic                    y_neg, y_small_neg, y_over, clip;
  logic [SAMPLE_BITS-1:0]  res;

  assign y_shr       = y_new >>> COEF_FRAC_BITS;
  assign y_neg       = y_new[Y_W-1];
  // strictly between -1 and 0 truncates to zero without clipping
  assign y_small_neg = (&y_new[Y_W-1:COEF_FRAC_BITS]) && (|y_new[COEF_FRAC_BITS-1:0]);
  assign y_over      = !y_neg && (y_shr > SMAX_Y);
  assign clip        = y_over || (y_neg && !y_small_neg);

  always_comb begin
    priority if (y_over) begin
      res = '1;
    end else if (y_neg) begin
      res = '0;
    end else begin
      res = y_shr[SAMPLE_BITS-1:0];
    end
  end

  // output register with skid slot
  logic [SAMPLE_BITS:0] out_word;

  iirbq_out_skid #(.W(SAMPLE_BITS + 1)) u_out_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_data_i  ({clip, res}),
    .pop_valid_o  (out_valid_o),
    .pop_stall_i  (out_stall_i),
    .pop_data_o   (out_word)
  );

  assign sample_out_o = out_word[SAMPLE_BITS-1:0];
  assign clipped_o    = out_word[SAMPLE_BITS];

  // the first output cell must hold exactly the value just computed
  a_y1_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (y1_data == $past(y_new)))
    else $error("output delay cell not loaded with new value");

  // the old first output moves down the row on each word
  a_y2_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (y2_data == $past(y1_data) && x2_data == $past(x1_data)))
    else $error("delay row did not shift");

  // a clipped result sits at one of the two bounds
  a_clip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |-> (sample_out_o == '0 || sample_out_o == '1))
    else $error("clipped result not at a bound");

endmodule

`default_nettype wire
